FILE: hw/rtl/tmprof_pkg.sv
// ----------------------------------------------------------------------------
// tmprof_pkg
// Shared types, register indexes and helpers for the trapezoidal profile block.
// ----------------------------------------------------------------------------
package tmprof_pkg;

   // register indexes on the csr port
   localparam logic [1:0] CSR_VELOCITY = 2'd0;
   localparam logic [1:0] CSR_ACCEL    = 2'd1;
   localparam logic [1:0] CSR_DISTANCE = 2'd2;

   // magnitude terms are capped at 2^32
   localparam logic [32:0] MAG_CAP = 33'h1_0000_0000;

   // per-move constants handed from the setup sequencer to the sample pipeline
   typedef struct packed {
      logic        busy;
      logic [30:0] acc;   // effective acceleration
      logic [30:0] vpk;   // peak velocity reached
      logic [32:0] ta;    // accel time, capped at 2^32
      logic [32:0] tatc;  // accel + cruise time, capped at 2^32
      logic [31:0] dur;   // total duration, saturated
      logic [32:0] pa;    // position at end of accel
      logic [32:0] pc;    // position gained while cruising
   } tmprof_prof_type;

   function automatic logic [32:0] cap_mag(input logic [127:0] val);
      return (val > 128'(MAG_CAP)) ? MAG_CAP : val[32:0];
   endfunction

endpackage

FILE: hw/rtl/tmprof_setup.sv
// ----------------------------------------------------------------------------
// tmprof_setup
// Sequencer that works out phase times, peak velocity and phase positions
// from the limits and distance, with a shared shift-add multiplier, a
// restoring divider and a bit-pair square root.
// ----------------------------------------------------------------------------
module tmprof_setup #(
   parameter int FRAC_BITS = 16
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [30:0]                 vel_limit,
   input  logic [30:0]                 acc_limit,
   input  logic [31:0]                 distance,
   output tmprof_pkg::tmprof_prof_type prof
);
   import tmprof_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE, ST_LOAD, ST_MUL_VV, ST_MUL_DA, ST_DIV_Q1, ST_DIV_R1, ST_SQRT,
      ST_DIV_TA, ST_DIV_TC, ST_MUL_AT, ST_MUL_PA, ST_MUL_PC, ST_FINISH
   } state_type;

   localparam logic [5:0]  LAST_STEP = 6'd63;
   localparam logic [5:0]  SQRT_LAST = 6'd31;
   localparam logic [63:0] SQRT_TOP  = 64'h4000_0000_0000_0000;

   state_type    state_ff;
   logic         busy_ff;
   logic [5:0]   cnt_ff;
   logic [127:0] mcand_ff, macc_ff;
   logic [63:0]  mplier_ff;
   logic [63:0]  dquo_ff;
   logic [31:0]  drem_ff, dsor_ff;
   logic [63:0]  sn_ff, sr_ff, sbit_ff;
   logic [30:0]  v_ff, a_ff, vp_ff;
   logic [31:0]  d_ff;
   logic         tri_ff;
   logic [61:0]  vv_ff;
   logic [63:0]  q1_ff, ta_ff, tc_ff;
   logic [32:0]  pa_ff, pc_ff, tas_ff, tatc_ff;
   logic [31:0]  dur_ff;

   logic [30:0]  v_eff, a_eff;
   logic [31:0]  d_abs;
   logic [127:0] mul_sum_in;
   logic [32:0]  div_sh;
   logic         div_ge;
   logic [31:0]  div_rem_in;
   logic [63:0]  div_quo_in;
   logic [63:0]  sq_trial, sn_in, sr_in;
   logic         sq_ge;
   logic [63:0]  dur_full;

   assign v_eff = (vel_limit == '0) ? 31'd1 : vel_limit;
   assign a_eff = (acc_limit == '0) ? 31'd1 : acc_limit;
   assign d_abs = distance[31] ? (32'd0 - distance) : distance;

   assign mul_sum_in = macc_ff + (mplier_ff[0] ? mcand_ff : '0);

   assign div_sh     = {drem_ff, dquo_ff[63]};
   assign div_ge     = div_sh >= {1'b0, dsor_ff};
   assign div_rem_in = div_ge ? 32'(div_sh - {1'b0, dsor_ff}) : div_sh[31:0];
   assign div_quo_in = {dquo_ff[62:0], div_ge};

   assign sq_trial = sr_ff + sbit_ff;
   assign sq_ge    = sn_ff >= sq_trial;
   assign sn_in    = sq_ge ? (sn_ff - sq_trial) : sn_ff;
   assign sr_in    = sq_ge ? ((sr_ff >> 1) + sbit_ff) : (sr_ff >> 1);

   assign dur_full = (ta_ff << 1) + tc_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
         busy_ff  <= 1'b1;
         cnt_ff   <= '0;
      end else if (start) begin
         state_ff <= ST_LOAD;
         busy_ff  <= 1'b1;
         cnt_ff   <= '0;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
            end
            ST_LOAD: begin
               v_ff      <= v_eff;
               a_ff      <= a_eff;
               d_ff      <= d_abs;
               mcand_ff  <= 128'(v_eff);
               mplier_ff <= 64'(v_eff);
               macc_ff   <= '0;
               cnt_ff    <= '0;
               state_ff  <= ST_MUL_VV;
            end
            ST_MUL_VV, ST_MUL_DA, ST_MUL_AT, ST_MUL_PA, ST_MUL_PC: begin
               macc_ff   <= mul_sum_in;
               mcand_ff  <= mcand_ff << 1;
               mplier_ff <= mplier_ff >> 1;
               cnt_ff    <= cnt_ff + 6'd1;
               if (cnt_ff == LAST_STEP) begin
                  macc_ff <= '0;
                  priority case (state_ff)
                     ST_MUL_VV: begin
                        vv_ff     <= mul_sum_in[61:0];
                        mcand_ff  <= 128'(d_ff);
                        mplier_ff <= 64'(a_ff);
                        state_ff  <= ST_MUL_DA;
                     end
                     ST_MUL_DA: begin
                        drem_ff <= '0;
                        dsor_ff <= 32'(a_ff);
                        if (128'(vv_ff) > mul_sum_in) begin
                           // too short to reach the limit: triangle
                           tri_ff   <= 1'b1;
                           dquo_ff  <= 64'(d_ff) << FRAC_BITS;
                           state_ff <= ST_DIV_Q1;
                        end else begin
                           tri_ff   <= 1'b0;
                           dquo_ff  <= 64'(v_ff) << FRAC_BITS;
                           state_ff <= ST_DIV_TA;
                        end
                     end
                     ST_MUL_AT: begin
                        vp_ff     <= tri_ff ? 31'(mul_sum_in[63:0] >> FRAC_BITS) : v_ff;
                        mcand_ff  <= 128'(mul_sum_in[63:0]);
                        mplier_ff <= ta_ff;
                        state_ff  <= ST_MUL_PA;
                     end
                     ST_MUL_PA: begin
                        pa_ff     <= cap_mag(mul_sum_in >> (2 * FRAC_BITS + 1));
                        mcand_ff  <= 128'(tc_ff);
                        mplier_ff <= 64'(vp_ff);
                        state_ff  <= ST_MUL_PC;
                     end
                     default: begin
                        pc_ff    <= cap_mag(mul_sum_in >> FRAC_BITS);
                        state_ff <= ST_FINISH;
                     end
                  endcase
               end
            end
            ST_DIV_Q1, ST_DIV_R1, ST_DIV_TA, ST_DIV_TC: begin
               dquo_ff <= div_quo_in;
               drem_ff <= div_rem_in;
               cnt_ff  <= cnt_ff + 6'd1;
               if (cnt_ff == LAST_STEP) begin
                  drem_ff <= '0;
                  priority case (state_ff)
                     ST_DIV_Q1: begin
                        q1_ff    <= div_quo_in;
                        dquo_ff  <= 64'(div_rem_in) << FRAC_BITS;
                        state_ff <= ST_DIV_R1;
                     end
                     ST_DIV_R1: begin
                        tc_ff <= '0;
                        if ((q1_ff >> (64 - FRAC_BITS)) != '0) begin
                           ta_ff     <= 64'(MAG_CAP);
                           mcand_ff  <= 128'(a_ff);
                           mplier_ff <= 64'(MAG_CAP);
                           state_ff  <= ST_MUL_AT;
                        end else begin
                           sn_ff    <= (q1_ff << FRAC_BITS) + div_quo_in;
                           sr_ff    <= '0;
                           sbit_ff  <= SQRT_TOP;
                           state_ff <= ST_SQRT;
                        end
                     end
                     ST_DIV_TA: begin
                        ta_ff    <= div_quo_in;
                        dquo_ff  <= 64'(d_ff) << FRAC_BITS;
                        dsor_ff  <= 32'(v_ff);
                        state_ff <= ST_DIV_TC;
                     end
                     default: begin
                        tc_ff     <= div_quo_in - ta_ff;
                        mcand_ff  <= 128'(a_ff);
                        mplier_ff <= ta_ff;
                        state_ff  <= ST_MUL_AT;
                     end
                  endcase
               end
            end
            ST_SQRT: begin
               sn_ff   <= sn_in;
               sr_ff   <= sr_in;
               sbit_ff <= sbit_ff >> 2;
               cnt_ff  <= cnt_ff + 6'd1;
               if (cnt_ff == SQRT_LAST) begin
                  cnt_ff    <= '0;
                  ta_ff     <= sr_in;
                  mcand_ff  <= 128'(a_ff);
                  mplier_ff <= sr_in;
                  state_ff  <= ST_MUL_AT;
               end
            end
            ST_FINISH: begin
               tas_ff   <= cap_mag(128'(ta_ff));
               tatc_ff  <= cap_mag(128'(ta_ff) + 128'(tc_ff));
               dur_ff   <= (dur_full > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : dur_full[31:0];
               busy_ff  <= 1'b0;
               state_ff <= ST_IDLE;
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign prof.busy = busy_ff;
   assign prof.acc  = a_ff;
   assign prof.vpk  = vp_ff;
   assign prof.ta   = tas_ff;
   assign prof.tatc = tatc_ff;
   assign prof.dur  = dur_ff;
   assign prof.pa   = pa_ff;
   assign prof.pc   = pc_ff;

endmodule

FILE: hw/rtl/trapezoidal_motion_profile.sv
// ----------------------------------------------------------------------------
// trapezoidal_motion_profile
// Evaluates position, velocity, finished flag and duration of a trapezoidal
// (or triangular) move at a streamed sample time, signed fixed point.
// ----------------------------------------------------------------------------
// channel | direction | content
// req     | in        | sample_time
// rsp     | out       | position, velocity, finished, total_duration
// csr     | in        | velocity_limit, accel_limit, move_distance writes
//
// One sample per cycle, while setup is idle and rsp is not stalled, through five
// register stages; the two 32x32 product stages set the depth.
// After reset and after every csr write the setup sequencer runs (shift-add
// multiplier, 64-step divider, 32-step root); req_tready stays low meanwhile.
// A stalled rsp holds each stage; bubbles between stages are squeezed out.
module trapezoidal_motion_profile #(
   parameter int FRAC_BITS = 16
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [31:0]  req_tdata,   // [31:0] sample_time
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // [31:0] position, [63:32] velocity, [64] finished, [96:65] total_duration
   output logic [103:0] rsp_tdata,
   input  logic         csr_we,
   input  logic [1:0]   csr_addr,
   input  logic [31:0]  csr_wdata
);
   import tmprof_pkg::*;

   typedef enum logic [1:0] {PH_ACCEL, PH_CRUISE, PH_DECEL} phase_type;

   tmprof_prof_type prof;
   logic [30:0] vel_ff, acc_ff;
   logic [31:0] dist_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vel_ff  <= 31'(1) << FRAC_BITS;
         acc_ff  <= 31'(1) << FRAC_BITS;
         dist_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_addr)
            CSR_VELOCITY: vel_ff  <= csr_wdata[30:0];
            CSR_ACCEL:    acc_ff  <= csr_wdata[30:0];
            CSR_DISTANCE: dist_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   tmprof_setup #(.FRAC_BITS(FRAC_BITS)) u_setup (
      .clock     (clock),
      .reset     (reset),
      .start     (csr_we),
      .vel_limit (vel_ff),
      .acc_limit (acc_ff),
      .distance  (dist_ff),
      .prof      (prof)
   );

   // stage enables, from the output back
   logic en1, en2, en3, en4, en5;
   logic s1_vld_ff, s2_vld_ff, s3_vld_ff, s4_vld_ff, rsp_vld_ff;

   assign en5 = !rsp_vld_ff || rsp_tready;
   assign en4 = !s4_vld_ff || en5;
   assign en3 = !s3_vld_ff || en4;
   assign en2 = !s2_vld_ff || en3;
   assign en1 = !s1_vld_ff || en2;
   assign req_tready = !prof.busy && en1;

   // stage 1: phase select and phase-local time
   phase_type   s1_ph_in;
   logic [31:0] s1_x_in;
   phase_type   s1_ph_ff, s2_ph_ff, s3_ph_ff, s4_ph_ff;
   logic [31:0] s1_x_ff, s2_x_ff;
   logic        s1_fin_ff, s2_fin_ff, s3_fin_ff, s4_fin_ff;
   logic        s1_zero_ff, s2_zero_ff, s3_zero_ff, s4_zero_ff;

   always_comb begin
      if ({1'b0, req_tdata} < prof.ta) begin
         s1_ph_in = PH_ACCEL;
         s1_x_in  = req_tdata;
      end else if ({1'b0, req_tdata} < prof.tatc) begin
         s1_ph_in = PH_CRUISE;
         s1_x_in  = req_tdata - prof.ta[31:0];
      end else begin
         s1_ph_in = PH_DECEL;
         s1_x_in  = req_tdata - prof.tatc[31:0];
      end
   end

   // stage 2: a*x and vp*x
   logic [62:0] s2_ma_in, s2_ma_ff;
   logic [62:0] s2_mv_in, s2_mv_ff;
   assign s2_ma_in = 63'(prof.acc) * 63'(s1_x_ff);
   assign s2_mv_in = 63'(prof.vpk) * 63'(s1_x_ff);

   // stage 3: (a*x)*x as two partial products, linear terms capped
   logic [62:0] s3_hi_in, s3_hi_ff;
   logic [63:0] s3_lo_in, s3_lo_ff;
   logic [32:0] s3_vterm_ff, s3_dv_ff, s4_vterm_ff, s4_dv_ff;
   assign s3_hi_in = 63'(s2_ma_ff[62:32]) * 63'(s2_x_ff);
   assign s3_lo_in = 64'(s2_ma_ff[31:0]) * 64'(s2_x_ff);

   // stage 4: half a x^2
   logic [94:0] s4_full;
   logic [32:0] s4_hterm_ff;
   assign s4_full = {s3_hi_ff, 32'b0} + 95'(s3_lo_ff);

   // output stage: combine phase terms, sign and saturate
   logic [34:0] up_mag, pmag;
   logic [32:0] vmag;
   logic [31:0] pos_in, vel_in, pos_sat, vel_sat;
   logic        neg;

   assign neg    = dist_ff[31];
   assign up_mag = 35'(prof.pa) + 35'(prof.pc) + 35'(s4_vterm_ff);

   always_comb begin
      unique case (s4_ph_ff)
         PH_ACCEL: begin
            pmag = 35'(s4_hterm_ff);
            vmag = s4_dv_ff;
         end
         PH_CRUISE: begin
            pmag = 35'(prof.pa) + 35'(s4_vterm_ff);
            vmag = 33'(prof.vpk);
         end
         default: begin
            // rounding can undershoot on the way down: clamp at zero
            pmag = (up_mag > 35'(s4_hterm_ff)) ? (up_mag - 35'(s4_hterm_ff)) : '0;
            vmag = (33'(prof.vpk) > s4_dv_ff) ? (33'(prof.vpk) - s4_dv_ff) : '0;
         end
      endcase
      if (neg) begin
         pos_sat = (pmag > 35'h0_8000_0000) ? 32'h8000_0000 : pmag[31:0];
         vel_sat = (vmag > 33'h0_8000_0000) ? 32'h8000_0000 : vmag[31:0];
         pos_sat = 32'd0 - pos_sat;
         vel_sat = 32'd0 - vel_sat;
      end else begin
         pos_sat = (pmag > 35'h0_7FFF_FFFF) ? 32'h7FFF_FFFF : pmag[31:0];
         vel_sat = (vmag > 33'h0_7FFF_FFFF) ? 32'h7FFF_FFFF : vmag[31:0];
      end
      priority if (s4_zero_ff) begin
         pos_in = '0;
         vel_in = '0;
      end else if (s4_fin_ff) begin
         pos_in = dist_ff;
         vel_in = '0;
      end else begin
         pos_in = pos_sat;
         vel_in = vel_sat;
      end
   end

   logic [103:0] rsp_data_in, rsp_data_ff;
   assign rsp_data_in = {7'b0, prof.dur, s4_fin_ff, vel_in, pos_in};

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff  <= 1'b0;
         s2_vld_ff  <= 1'b0;
         s3_vld_ff  <= 1'b0;
         s4_vld_ff  <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         if (en1) s1_vld_ff  <= req_tvalid && req_tready;
         if (en2) s2_vld_ff  <= s1_vld_ff;
         if (en3) s3_vld_ff  <= s2_vld_ff;
         if (en4) s4_vld_ff  <= s3_vld_ff;
         if (en5) rsp_vld_ff <= s4_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en1) begin
         s1_ph_ff   <= s1_ph_in;
         s1_x_ff    <= s1_x_in;
         s1_fin_ff  <= req_tdata >= prof.dur;
         s1_zero_ff <= req_tdata == '0;
      end
      if (en2) begin
         s2_ma_ff   <= s2_ma_in;
         s2_mv_ff   <= s2_mv_in;
         s2_x_ff    <= s1_x_ff;
         s2_ph_ff   <= s1_ph_ff;
         s2_fin_ff  <= s1_fin_ff;
         s2_zero_ff <= s1_zero_ff;
      end
      if (en3) begin
         s3_hi_ff    <= s3_hi_in;
         s3_lo_ff    <= s3_lo_in;
         s3_vterm_ff <= cap_mag(128'(s2_mv_ff >> FRAC_BITS));
         s3_dv_ff    <= cap_mag(128'(s2_ma_ff >> FRAC_BITS));
         s3_ph_ff    <= s2_ph_ff;
         s3_fin_ff   <= s2_fin_ff;
         s3_zero_ff  <= s2_zero_ff;
      end
      if (en4) begin
         s4_hterm_ff <= cap_mag(128'(s4_full >> (2 * FRAC_BITS + 1)));
         s4_vterm_ff <= s3_vterm_ff;
         s4_dv_ff    <= s3_dv_ff;
         s4_ph_ff    <= s3_ph_ff;
         s4_fin_ff   <= s3_fin_ff;
         s4_zero_ff  <= s3_zero_ff;
      end
      if (en5) rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

FILE: test/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for trapezoidal_motion_profile. Streams sample times
// under a range of limit and distance settings, predicts position, velocity,
// finished flag and duration for each accepted item, and checks every result
// in order while both sides idle and stall at random.
// ----------------------------------------------------------------------------
module testbench;
   import tmprof_pkg::*;

   localparam int          FB    = 16;
   localparam logic [63:0] CAP64 = 64'h1_0000_0000;
   localparam logic [63:0] M32   = 64'hFFFF_FFFF;

   // lowest bits last, matching rsp_tdata
   typedef struct packed {
      logic [31:0] duration;
      logic        finished;
      logic [31:0] velocity;
      logic [31:0] position;
   } sample_result_type;

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [31:0]  req_tdata;
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [103:0] rsp_tdata;
   logic         csr_we;
   logic [1:0]   csr_addr;
   logic [31:0]  csr_wdata;

   // predictor copy of the registers
   logic [30:0]        lim_vel;
   logic [30:0]        lim_acc;
   logic signed [31:0] move_dist;

   sample_result_type pending_results[$];
   int  errors;
   bit  send_gaps;
   bit  recv_stalls;
   bit  long_hold;
   int  stall_left;
   longint cycles;

   trapezoidal_motion_profile #(.FRAC_BITS(FB)) u_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_we(csr_we), .csr_addr(csr_addr), .csr_wdata(csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic logic [63:0] int_root(input logic [63:0] n);
      logic [63:0] r, b;
      r = 0;
      b = 64'h4000_0000_0000_0000;
      while (b > n) b = b >> 2;
      while (b != 0) begin
         if (n >= r + b) begin
            n = n - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   // floor(a*b / 2^s), capped at 2^32
   function automatic logic [63:0] scaled_prod(input logic [63:0] a, input logic [63:0] b,
                                               input int s);
      logic [127:0] p;
      p = (128'(a) * 128'(b)) >> s;
      return (p > 128'(CAP64)) ? CAP64 : p[63:0];
   endfunction

   function automatic logic [63:0] half_acc_sq(input logic [63:0] a, input logic [63:0] t);
      return scaled_prod(a * t, t, 2 * FB + 1);
   endfunction

   function automatic sample_result_type profile_at(input logic [31:0] ts);
      sample_result_type res;
      logic [63:0] v, a, d, t, ta, tc, vp, dur, dur_out, pmag, vmag;
      logic [63:0] num, q1, r1, td, up, down, dv;
      logic signed [63:0] ds;
      logic neg, fin;
      v  = (lim_vel != 0) ? 64'(lim_vel) : 64'd1;
      a  = (lim_acc != 0) ? 64'(lim_acc) : 64'd1;
      ds = move_dist;
      neg = move_dist < 0;
      d  = neg ? 64'(-ds) : 64'(ds);
      t  = 64'(ts);
      pmag = 0;
      vmag = 0;
      if (v * v > d * a) begin
         // too short to reach the limit: triangular profile
         num = d << FB;
         q1  = num / a;
         r1  = num % a;
         ta  = int_root((q1 << FB) + ((r1 << FB) / a));
         if (ta > CAP64) ta = CAP64;
         tc  = 0;
         vp  = (a * ta) >> FB;
      end else begin
         ta = (v << FB) / a;
         tc = ((d << FB) / v) - ta;
         vp = v;
      end
      dur     = 2 * ta + tc;
      dur_out = (dur > M32) ? M32 : dur;
      fin     = t >= dur_out;
      if (t == 0) begin
         res.position = '0;
         res.velocity = '0;
      end else if (fin) begin
         res.position = move_dist;
         res.velocity = '0;
      end else begin
         if (t < ta) begin
            pmag = half_acc_sq(a, t);
            vmag = scaled_prod(a, t, FB);
         end else if (t < ta + tc) begin
            pmag = half_acc_sq(a, ta) + scaled_prod(vp, t - ta, FB);
            vmag = vp;
         end else begin
            td   = t - ta - tc;
            up   = half_acc_sq(a, ta) + scaled_prod(vp, tc, FB) + scaled_prod(vp, td, FB);
            down = half_acc_sq(a, td);
            dv   = scaled_prod(a, td, FB);
            pmag = (up > down) ? up - down : 64'd0;
            vmag = (vp > dv) ? vp - dv : 64'd0;
         end
         if (neg) begin
            if (pmag > 64'h8000_0000) pmag = 64'h8000_0000;
            if (vmag > 64'h8000_0000) vmag = 64'h8000_0000;
            res.position = 32'(64'd0 - pmag);
            res.velocity = 32'(64'd0 - vmag);
         end else begin
            if (pmag > 64'h7FFF_FFFF) pmag = 64'h7FFF_FFFF;
            if (vmag > 64'h7FFF_FFFF) vmag = 64'h7FFF_FFFF;
            res.position = pmag[31:0];
            res.velocity = vmag[31:0];
         end
      end
      res.finished = fin;
      res.duration = dur_out[31:0];
      return res;
   endfunction

   task automatic send_sample(input logic [31:0] ts);
      if (send_gaps && $urandom_range(0, 5) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 13)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= ts;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      pending_results.push_back(profile_at(ts));
   endtask

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_results.size() != 0) @(posedge clock);
      repeat (12) @(posedge clock);
   endtask

   // all three registers in consecutive cycles, block idle
   task automatic write_limits(input logic [31:0] vel, input logic [31:0] acc,
                               input logic [31:0] dist_word);
      wait_idle();
      csr_we <= 1'b1; csr_addr <= CSR_VELOCITY; csr_wdata <= vel;
      @(posedge clock);
      csr_addr <= CSR_ACCEL; csr_wdata <= acc;
      @(posedge clock);
      csr_addr <= CSR_DISTANCE; csr_wdata <= dist_word;
      @(posedge clock);
      csr_we <= 1'b0;
      lim_vel   = vel[30:0];
      lim_acc   = acc[30:0];
      move_dist = dist_word;
   endtask

   // times at and around the phase edges of the current move
   task automatic send_phase_edges();
      logic [31:0] dur;
      dur = profile_at(32'd0).duration;
      send_sample(32'd1);
      send_sample(dur >> 2);
      send_sample(dur >> 1);
      send_sample(dur - 32'd1);
      send_sample(dur);
      send_sample(32'hFFFF_FFFF);
   endtask

   task automatic test_reset_defaults();
      send_sample(32'd0);
      send_sample(32'h0001_0000);
      send_sample(32'hFFFF_FFFF);
   endtask

   task automatic test_directed();
      // plain trapezoid, then triangle, then a negative move
      write_limits(32'h0001_0000, 32'h0002_0000, 32'h000A_0000);
      send_phase_edges();
      write_limits(32'h0010_0000, 32'h0001_0000, 32'h0002_0000);
      send_phase_edges();
      write_limits(32'h0002_0000, 32'h0001_0000, 32'hFFF0_0000);
      send_phase_edges();
      // zero limits count as one LSB; most negative distance
      write_limits(32'd0, 32'd0, 32'h8000_0000);
      send_sample(32'd0);
      send_sample(32'h8000_0000);
      // register extremes
      write_limits(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
      send_sample(32'd1);
      send_sample(32'h0000_8000);
      send_sample(32'hFFFF_FFFF);
   endtask

   function automatic logic [31:0] rand_width(input int lo, input int hi);
      int w;
      w = $urandom_range(lo, hi);
      return $urandom & ((w >= 32) ? 32'hFFFF_FFFF : ((32'd1 << w) - 32'd1));
   endfunction

   // sample times mostly inside the current move
   task automatic send_random(input int n);
      logic [31:0] dur, ts;
      dur = profile_at(32'd0).duration;
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(0, 9) < 8)
            ts = (dur == 32'hFFFF_FFFF) ? $urandom : $urandom_range(0, dur + 32'd1);
         else
            ts = $urandom;
         send_sample(ts);
      end
   endtask

   task automatic random_phase(input int n);
      logic [31:0] dist_val;
      dist_val = rand_width(1, 32);
      if ($urandom_range(0, 1) == 0) dist_val = -dist_val;
      write_limits(rand_width(1, 31), rand_width(1, 31), dist_val);
      send_random(n);
   endtask

   task automatic test_random();
      for (int ph = 0; ph < 16; ph++) begin
         send_gaps   = (ph % 4) != 3;
         recv_stalls = (ph % 5) != 4;
         random_phase(50);
      end
   endtask

   // receiver holds off long enough to back the block up
   task automatic test_backpressure();
      send_gaps = 1'b0;
      random_phase(0);
      // setup runs first, so the hold lands on a block that takes items
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      fork
         begin
            long_hold = 1'b1;
            repeat (300) @(posedge clock);
            long_hold = 1'b0;
         end
      join_none
      send_random(60);
      // sender pauses until the pipeline has drained, then resumes
      wait_idle();
      for (int i = 0; i < 20; i++) send_sample($urandom);
   endtask

   task automatic test_full_rate();
      send_gaps   = 1'b0;
      recv_stalls = 1'b0;
      for (int ph = 0; ph < 3; ph++) random_phase(60);
   endtask

   // result checker and receiver stalls
   always @(posedge clock) begin
      sample_result_type got, exp_res;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata[96:0];
         if (pending_results.size() == 0) begin
            $error("unexpected result item %h", rsp_tdata);
            errors++;
         end else begin
            exp_res = pending_results.pop_front();
            if (got.position !== exp_res.position) begin
               $error("position: expected %h, got %h", exp_res.position, got.position);
               errors++;
            end
            if (got.velocity !== exp_res.velocity) begin
               $error("velocity: expected %h, got %h", exp_res.velocity, got.velocity);
               errors++;
            end
            if (got.finished !== exp_res.finished) begin
               $error("finished: expected %b, got %b", exp_res.finished, got.finished);
               errors++;
            end
            if (got.duration !== exp_res.duration) begin
               $error("total_duration: expected %h, got %h", exp_res.duration,
                      got.duration);
               errors++;
            end
         end
      end
      if (long_hold) begin
         rsp_tready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_tready <= 1'b0;
      end else if (recv_stalls && $urandom_range(0, 6) == 0) begin
         stall_left = $urandom_range(1, 13) - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > 2_000_000) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   initial begin
      errors      = 0;
      cycles      = 0;
      stall_left  = 0;
      long_hold   = 1'b0;
      send_gaps   = 1'b1;
      recv_stalls = 1'b1;
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      rsp_tready  = 1'b0;
      csr_we      = 1'b0;
      csr_addr    = CSR_VELOCITY;
      csr_wdata   = '0;
      lim_vel     = 31'h0001_0000;
      lim_acc     = 31'h0001_0000;
      move_dist   = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      test_reset_defaults();
      test_directed();
      test_random();
      test_backpressure();
      test_full_rate();
      wait_idle();
      repeat (20) @(posedge clock);
      if (errors == 0 && pending_results.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
